// ===== hdl/gast_pkg.sv =====
// ----------------------------------------------------------------------------
// Gimbal axis slew tracker package
// Shared widths, codes, command and status types and helper functions for
// the slew tracker controller, datapath and top level.
// ----------------------------------------------------------------------------
package gast_pkg;

   // Fixed-point format defaults.
   localparam int ANGLE_FRAC_BITS_DEF = 12;
   localparam int TIME_FRAC_BITS_DEF  = 20;

   // Field widths.
   localparam int ACT_W    = 2;
   localparam int ANG_W    = 22;
   localparam int DT_W     = 21;
   localparam int RATE_W   = 23;
   localparam int FRATE_W  = 22;
   localparam int MODE_W   = 2;
   localparam int PROD_W   = RATE_W + DT_W;
   localparam int SUM_W    = PROD_W + 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 23;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 24;

   // Action codes carried with each request.
   localparam logic [ACT_W-1:0] ACT_SET_CMD = 2'd0;
   localparam logic [ACT_W-1:0] ACT_PRESET  = 2'd1;
   localparam logic [ACT_W-1:0] ACT_TICK    = 2'd2;

   // Control modes.
   localparam logic [MODE_W-1:0] MODE_TRACK = 2'd0;
   localparam logic [MODE_W-1:0] MODE_RATE  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_FIXED = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_CONTROL_MODE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_AXIS_ENABLED  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FREE_ROTATE   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TRACKING_RATE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FIXED_RATE    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_LIMIT     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_LIMIT     = 3'd6;

   // Reset values of the limits.
   localparam logic signed [ANG_W-1:0] MIN_LIMIT_RST = -22'sd1474560;
   localparam logic signed [ANG_W-1:0] MAX_LIMIT_RST = 22'sd1474560;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic mul;
      logic step;
      logic commit;
   } gast_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic rsp_free;
   } gast_status_type;

   // Sign-extends an angle to the wide arithmetic width.
   function automatic logic signed [SUM_W-1:0] ext_angle(input logic signed [ANG_W-1:0] a);
      ext_angle = {{(SUM_W-ANG_W){a[ANG_W-1]}}, a};
   endfunction

   // Saturates a wide value to the signed angle range.
   function automatic logic signed [ANG_W-1:0] sat_angle(input logic signed [SUM_W-1:0] x);
      logic signed [SUM_W-1:0] lo;
      logic signed [SUM_W-1:0] hi;
      lo = ext_angle({1'b1, {(ANG_W-1){1'b0}}});
      hi = ext_angle({1'b0, {(ANG_W-1){1'b1}}});
      if (x < lo) begin
         sat_angle = lo[ANG_W-1:0];
      end else if (x > hi) begin
         sat_angle = hi[ANG_W-1:0];
      end else begin
         sat_angle = x[ANG_W-1:0];
      end
   endfunction

endpackage

// ===== hdl/gast_ctrl.sv =====
// ----------------------------------------------------------------------------
// Slew tracker controller
// Sequences each request through capture, multiply, add and commit, and
// holds the commit back while the previous result still waits.
// ----------------------------------------------------------------------------
module gast_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  gast_pkg::gast_status_type status,
   output gast_pkg::gast_cmd_type    cmd
);
   import gast_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_MUL    = 2'd1;
   localparam logic [1:0] ST_STEP   = 2'd2;
   localparam logic [1:0] ST_COMMIT = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   // Next state and commands.
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_STEP;
         end
         ST_STEP: begin
            cmd.step = 1'b1;
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (status.rsp_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hdl/gast_dp.sv =====
// ----------------------------------------------------------------------------
// Slew tracker datapath
// Holds the configuration registers and axis state, forms rate*dt on one
// multiplier, adds the step and commits the clamped, snapped or wrapped angle.
// ----------------------------------------------------------------------------
module gast_dp #(
   parameter int ANGLE_FRAC_BITS = gast_pkg::ANGLE_FRAC_BITS_DEF,
   parameter int TIME_FRAC_BITS  = gast_pkg::TIME_FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  gast_pkg::gast_cmd_type              cmd,
   output gast_pkg::gast_status_type           status,
   input  logic [gast_pkg::ACT_W-1:0]          req_action,
   input  logic signed [gast_pkg::ANG_W-1:0]   req_angle_value,
   input  logic [gast_pkg::DT_W-1:0]           req_delta_time,
   input  logic                                csr_valid,
   input  logic [gast_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [gast_pkg::CSR_DATA_W-1:0]     csr_data,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic signed [gast_pkg::ANG_W-1:0]   rsp_current_angle,
   output logic                                rsp_on_target
);
   import gast_pkg::*;

   localparam logic signed [SUM_W-1:0] FULL_TURN = SUM_W'(360) <<< ANGLE_FRAC_BITS;

   // Configuration registers.
   logic [MODE_W-1:0]         mode_ff;
   logic                      enabled_ff;
   logic                      free_ff;
   logic signed [RATE_W-1:0]  track_ff;
   logic [FRATE_W-1:0]        fixed_ff;
   logic signed [ANG_W-1:0]   min_ff;
   logic signed [ANG_W-1:0]   max_ff;

   // Axis state.
   logic signed [ANG_W-1:0]   axis_ff;
   logic signed [ANG_W-1:0]   target_ff;

   // Captured request and intermediate results.
   logic [ACT_W-1:0]          act_ff;
   logic signed [ANG_W-1:0]   ang_ff;
   logic [DT_W-1:0]           dt_ff;
   logic [PROD_W-1:0]         prod_ff;
   logic [PROD_W-1:0]         prod_in;
   logic                      neg_ff;
   logic                      neg_in;
   logic signed [SUM_W-1:0]   next_ff;
   logic signed [SUM_W-1:0]   next_in;

   // Result register.
   logic                      rsp_valid_ff;
   logic signed [ANG_W-1:0]   rsp_angle_ff;
   logic                      rsp_on_ff;

   logic signed [RATE_W-1:0]  rate_sel;
   logic [RATE_W-1:0]         rate_mag;
   logic [PROD_W-1:0]         step_mag;
   logic signed [SUM_W-1:0]   step_s;
   logic signed [SUM_W-1:0]   cur_w;
   logic signed [SUM_W-1:0]   cmd_w;
   logic signed [SUM_W-1:0]   lo_w;
   logic signed [SUM_W-1:0]   hi_w;
   logic signed [SUM_W-1:0]   clamped;
   logic signed [SUM_W-1:0]   moved;
   logic signed [ANG_W-1:0]   axis_in;
   logic signed [ANG_W-1:0]   target_in;

   assign cur_w = ext_angle(axis_ff);
   assign cmd_w = ext_angle(target_ff);
   assign lo_w  = ext_angle(min_ff);
   assign hi_w  = ext_angle(max_ff);

   // Configuration writes; the port never stalls.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_TRACK;
         enabled_ff <= 1'b1;
         free_ff    <= 1'b0;
         track_ff   <= '0;
         fixed_ff   <= '0;
         min_ff     <= MIN_LIMIT_RST;
         max_ff     <= MAX_LIMIT_RST;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_CONTROL_MODE:  mode_ff    <= csr_data[MODE_W-1:0];
            CSR_AXIS_ENABLED:  enabled_ff <= csr_data[0];
            CSR_FREE_ROTATE:   free_ff    <= csr_data[0];
            CSR_TRACKING_RATE: track_ff   <= $signed(csr_data[RATE_W-1:0]);
            CSR_FIXED_RATE:    fixed_ff   <= csr_data[FRATE_W-1:0];
            CSR_MIN_LIMIT:     min_ff     <= $signed(csr_data[ANG_W-1:0]);
            CSR_MAX_LIMIT:     max_ff     <= $signed(csr_data[ANG_W-1:0]);
            default: begin
            end
         endcase
      end
   end

   // Multiply stage: magnitude of the selected rate times the elapsed time.
   always_comb begin
      if (mode_ff == MODE_FIXED) begin
         rate_sel = $signed({1'b0, fixed_ff});
      end else begin
         rate_sel = track_ff;
      end
      neg_in   = rate_sel[RATE_W-1];
      rate_mag = neg_in ? (RATE_W'(0) - rate_sel) : rate_sel;
      prod_in  = {{DT_W{1'b0}}, rate_mag} * {{RATE_W{1'b0}}, dt_ff};
   end

   // Add stage: truncated step with its sign, applied toward the command outside rate mode.
   always_comb begin
      step_mag = prod_ff >> TIME_FRAC_BITS;
      step_s   = $signed({2'b00, step_mag});
      if (neg_ff) begin
         step_s = -step_s;
      end
      if (mode_ff != MODE_RATE && target_ff < axis_ff) begin
         next_in = cur_w - step_s;
      end else begin
         next_in = cur_w + step_s;
      end
   end

   // Commit stage: clamp, snap or wrap, saturate, then apply the action.
   always_comb begin
      if (next_ff < lo_w) begin
         clamped = lo_w;
      end else if (next_ff < hi_w) begin
         clamped = next_ff;
      end else begin
         clamped = hi_w;
      end
      moved = clamped;
      if (mode_ff == MODE_RATE) begin
         if (free_ff) begin
            if (next_ff > FULL_TURN) begin
               moved = next_ff - FULL_TURN;
            end else if (next_ff < 0) begin
               moved = next_ff + FULL_TURN;
            end else begin
               moved = next_ff;
            end
         end
      end else if ((clamped < cmd_w && cur_w > cmd_w) ||
                   (clamped > cmd_w && cur_w < cmd_w)) begin
         // The step overshot the command, so it lands on it.
         moved = cmd_w;
      end

      axis_in   = axis_ff;
      target_in = target_ff;
      case (act_ff)
         ACT_SET_CMD: target_in = ang_ff;
         ACT_PRESET:  axis_in   = ang_ff;
         ACT_TICK: begin
            if (enabled_ff) begin
               case (mode_ff)
                  MODE_TRACK, MODE_FIXED: begin
                     if (axis_ff != target_ff) begin
                        axis_in = sat_angle(moved);
                     end
                  end
                  MODE_RATE: axis_in = sat_angle(moved);
                  default: begin
                  end
               endcase
            end
         end
         default: begin
         end
      endcase
   end

   // Request capture and pipeline registers.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         act_ff <= req_action;
         ang_ff <= req_angle_value;
         dt_ff  <= req_delta_time;
      end
      if (cmd.mul) begin
         prod_ff <= prod_in;
         neg_ff  <= neg_in;
      end
      if (cmd.step) begin
         next_ff <= next_in;
      end
      if (cmd.commit) begin
         rsp_angle_ff <= axis_in;
         rsp_on_ff    <= (axis_in == target_in);
      end
   end

   // Axis state and result valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         axis_ff      <= '0;
         target_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.commit) begin
            axis_ff      <= axis_in;
            target_ff    <= target_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign status.rsp_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid        = rsp_valid_ff;
   assign rsp_current_angle = rsp_angle_ff;
   assign rsp_on_target     = rsp_on_ff;

endmodule

// ===== hdl/gimbal_axis_slew_tracker_unit.sv =====
// ----------------------------------------------------------------------------
// Gimbal axis slew tracker
// One gimbal axis: sets the command, presets the angle or moves the axis on
// a time tick, with slew limiting, angle limits and free rotation.
// ----------------------------------------------------------------------------
// The request is captured at acceptance, then makes one pass through the
// shared rate*dt multiplier, then the wide add of the step, and finally the
// commit of clamp, snap and saturation. The controller takes no new request
// before the commit, and the next request is accepted on the cycle after the
// commit. A result left waiting holds the following commit back until it is
// taken.
// Configuration writes are accepted on every cycle and must be made only
// while the unit is idle.
// ----------------------------------------------------------------------------
module gimbal_axis_slew_tracker_unit #(
   parameter int ANGLE_FRAC_BITS = gast_pkg::ANGLE_FRAC_BITS_DEF,
   parameter int TIME_FRAC_BITS  = gast_pkg::TIME_FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // Request channel.
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // angle_value [21:0], delta_time [42:22], zero [47:43]
   input  logic [gast_pkg::REQ_DATA_W-1:0]     req_tdata,
   // action [1:0]
   input  logic [gast_pkg::ACT_W-1:0]          req_tuser,
   // Result channel.
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // current_angle [21:0], on_target [22], zero [23]
   output logic [gast_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // Configuration write channel.
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [gast_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [gast_pkg::CSR_DATA_W-1:0]     csr_data
);
   import gast_pkg::*;

   gast_cmd_type            cmd;
   gast_status_type         status;
   logic signed [ANG_W-1:0] rsp_angle;
   logic                    rsp_on;

   assign csr_ready = 1'b1;

   // Controller.
   gast_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // Datapath.
   gast_dp #(
      .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
      .TIME_FRAC_BITS  (TIME_FRAC_BITS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_action        (req_tuser),
      .req_angle_value   ($signed(req_tdata[ANG_W-1:0])),
      .req_delta_time    (req_tdata[ANG_W+DT_W-1:ANG_W]),
      .csr_valid         (csr_valid),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_tready        (rsp_tready),
      .rsp_current_angle (rsp_angle),
      .rsp_on_target     (rsp_on)
   );

   // Result packing.
   assign rsp_tdata = {1'b0, rsp_on, rsp_angle};

endmodule

// ===== verif/gimbal_axis_slew_tracker_unit_tb.sv =====
// ----------------------------------------------------------------------------
// Gimbal axis slew tracker testbench
// Drives command, preset and tick requests into the slew tracker, predicts
// the axis angle and on-target flag of every request with an independent
// model of the axis, and compares each result field by field. The run
// passes through several register settings, with random idling on both
// channels, one long result stall and a final stretch without idling.
// ----------------------------------------------------------------------------
module gimbal_axis_slew_tracker_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import gast_pkg::*;

   // Codes that the package leaves unnamed.
   localparam logic [ACT_W-1:0]  ACT_NONE  = 2'd3;
   localparam logic [MODE_W-1:0] MODE_HOLD = 2'd3;

   // Extremes of the fields and the fixed-point constants.
   localparam int     ANG_HI      = 2097151;
   localparam int     ANG_LO      = -2097152;
   localparam int     DT_MAX      = 2097151;
   localparam int     RATE_MAX    = 4194303;
   localparam int     RATE_MIN    = -4194304;
   localparam int     FRATE_MAX   = 4194303;
   localparam int     LIMIT_SPAN  = 1474560;
   localparam longint FULL_TURN   = 64'sd360 <<< ANGLE_FRAC_BITS_DEF;
   localparam int     SETTLE_CYCLES = 8;
   localparam int     LONG_HOLD   = 200;
   localparam int     CYCLE_LIMIT = 400000;

   typedef struct {
      logic [ACT_W-1:0]        action;
      logic signed [ANG_W-1:0] angle;
      logic [DT_W-1:0]         dt;
   } axis_request_type;

   typedef struct {
      logic signed [ANG_W-1:0] angle;
      logic                    on_target;
   } axis_reading_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [ACT_W-1:0]      req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // Mirror of the registers and the axis state.
   logic [MODE_W-1:0]        m_mode;
   logic                     m_enabled;
   logic                     m_free_rotate;
   logic signed [RATE_W-1:0] m_track_rate;
   logic [FRATE_W-1:0]       m_fixed_rate;
   logic signed [ANG_W-1:0]  m_min_limit;
   logic signed [ANG_W-1:0]  m_max_limit;
   logic signed [ANG_W-1:0]  m_angle;
   logic signed [ANG_W-1:0]  m_target;

   axis_request_type pending_requests[$];
   axis_reading_type due_readings[$];

   int  requests_queued = 0;
   int  requests_accepted = 0;
   int  readings_checked = 0;
   int  csr_writes_seen = 0;
   int  fail_count = 0;
   int  cycle_count = 0;
   int  send_gap = 0;
   int  hold_left = 0;
   int  hold_asks = 0;
   int  hold_seen = 0;
   bit  calm = 1'b0;
   logic req_taken = 1'b0;

   gimbal_axis_slew_tracker_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // Clock with a period of 8 ns.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Watchdog on the length of the run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL gimbal_axis_slew_tracker_unit");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Axis model
   // ------------------------------------------------------------------------

   function automatic longint limit_clamp(longint x);
      longint lo;
      longint hi;
      lo = m_min_limit;
      hi = m_max_limit;
      return (x < lo) ? lo : ((x < hi) ? x : hi);
   endfunction

   // rate * dt scaled back to angle units, truncated toward zero.
   function automatic longint slew_step(longint rate, longint dt);
      longint mag;
      mag = (rate < 0) ? -rate : rate;
      mag = (mag * dt) >>> TIME_FRAC_BITS_DEF;
      return (rate < 0) ? -mag : mag;
   endfunction

   function automatic longint saturate_angle(longint x);
      if (x < ANG_LO) return ANG_LO;
      if (x > ANG_HI) return ANG_HI;
      return x;
   endfunction

   // Applies one request to the axis and returns the reading that follows.
   function automatic axis_reading_type advance_axis(axis_request_type r);
      axis_reading_type res;
      longint cur;
      longint cmd;
      longint nxt;
      longint rate;
      longint step;
      cur = m_angle;
      cmd = m_target;
      nxt = cur;
      case (r.action)
         ACT_SET_CMD: m_target = r.angle;
         ACT_PRESET:  m_angle = r.angle;
         ACT_TICK: begin
            if (m_enabled) begin
               if (m_mode == MODE_TRACK || m_mode == MODE_FIXED) begin
                  if (m_mode == MODE_TRACK) begin
                     rate = m_track_rate;
                  end else begin
                     rate = m_fixed_rate;
                  end
                  // Step toward the command, clamp, and snap on overshoot.
                  if (cur != cmd) begin
                     step = slew_step(rate, r.dt);
                     nxt = limit_clamp((cmd < cur) ? cur - step : cur + step);
                     if ((nxt < cmd && cur > cmd) || (nxt > cmd && cur < cmd)) begin
                        nxt = cmd;
                     end
                  end
               end else if (m_mode == MODE_RATE) begin
                  nxt = cur + slew_step(m_track_rate, r.dt);
                  if (m_free_rotate) begin
                     if (nxt > FULL_TURN) begin
                        nxt = nxt - FULL_TURN;
                     end else if (nxt < 0) begin
                        nxt = nxt + FULL_TURN;
                     end
                  end else begin
                     nxt = limit_clamp(nxt);
                  end
               end
               m_angle = saturate_angle(nxt);
            end
         end
         default: ;
      endcase
      res.angle = m_angle;
      res.on_target = (m_angle == m_target);
      return res;
   endfunction

   function automatic void apply_register(logic [CSR_IDX_W-1:0] idx,
                                          logic [CSR_DATA_W-1:0] value);
      case (idx)
         CSR_CONTROL_MODE:  m_mode = value[MODE_W-1:0];
         CSR_AXIS_ENABLED:  m_enabled = value[0];
         CSR_FREE_ROTATE:   m_free_rotate = value[0];
         CSR_TRACKING_RATE: m_track_rate = value[RATE_W-1:0];
         CSR_FIXED_RATE:    m_fixed_rate = value[FRATE_W-1:0];
         CSR_MIN_LIMIT:     m_min_limit = value[ANG_W-1:0];
         CSR_MAX_LIMIT:     m_max_limit = value[ANG_W-1:0];
         default: ;
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Monitor: checks results, then mirrors writes and accepted requests.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      axis_reading_type want;
      axis_reading_type got;
      axis_request_type seen;
      req_taken <= req_tvalid && req_tready;
      if (reset) begin
         m_mode = MODE_TRACK;
         m_enabled = 1'b1;
         m_free_rotate = 1'b0;
         m_track_rate = '0;
         m_fixed_rate = '0;
         m_min_limit = MIN_LIMIT_RST;
         m_max_limit = MAX_LIMIT_RST;
         m_angle = '0;
         m_target = '0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.angle = rsp_tdata[ANG_W-1:0];
            got.on_target = rsp_tdata[ANG_W];
            if (due_readings.size() == 0) begin
               $error("result with no request outstanding: current_angle %0d", got.angle);
               fail_count++;
            end else begin
               want = due_readings.pop_front();
               readings_checked++;
               if (got.angle !== want.angle) begin
                  $error("current_angle: expected %0d, actual %0d", want.angle, got.angle);
                  fail_count++;
               end
               if (got.on_target !== want.on_target) begin
                  $error("on_target: expected %0b, actual %0b", want.on_target,
                         got.on_target);
                  fail_count++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            apply_register(csr_index, csr_data);
            csr_writes_seen++;
         end
         if (req_tvalid && req_tready) begin
            seen.action = req_tuser;
            seen.angle = req_tdata[ANG_W-1:0];
            seen.dt = req_tdata[ANG_W +: DT_W];
            due_readings.push_back(advance_axis(seen));
            requests_accepted++;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Request driver, fed from the pending queue, with random idle bursts.
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      axis_request_type item;
      if (!reset && (!req_tvalid || req_taken)) begin
         if (send_gap != 0) begin
            send_gap <= send_gap - 1;
            req_tvalid <= 1'b0;
         end else if (pending_requests.size() != 0 && !calm
                      && $urandom_range(0, 11) == 0) begin
            send_gap <= $urandom_range(0, 15);
            req_tvalid <= 1'b0;
         end else if (pending_requests.size() != 0) begin
            item = pending_requests.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= {{(REQ_DATA_W - ANG_W - DT_W){1'b0}}, item.dt, item.angle};
            req_tuser <= item.action;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Result side: random stalls, and one long hold-off when asked for.
   always @(negedge clock) begin
      if (hold_asks != hold_seen) begin
         hold_seen <= hold_asks;
         hold_left <= LONG_HOLD;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
         hold_left <= $urandom_range(0, 15);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------

   task automatic queue_request(input logic [ACT_W-1:0] action, input int angle,
                                input int dt);
      axis_request_type r;
      r.action = action;
      r.angle = angle[ANG_W-1:0];
      r.dt = dt[DT_W-1:0];
      pending_requests.push_back(r);
      requests_queued++;
   endtask

   // Waits until every request has been taken and answered.
   task automatic settle();
      @(negedge clock);
      while (requests_accepted != requests_queued || readings_checked != requests_accepted)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int value);
      int seen;
      @(negedge clock);
      seen = csr_writes_seen;
      csr_index <= idx;
      csr_data <= value[CSR_DATA_W-1:0];
      csr_valid <= 1'b1;
      do @(negedge clock); while (csr_writes_seen == seen);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic int random_angle();
      if ($urandom_range(0, 6) == 0) return int'($urandom());
      return int'($urandom_range(0, 2 * LIMIT_SPAN)) - LIMIT_SPAN;
   endfunction

   function automatic int random_dt();
      if ($urandom_range(0, 9) == 0) return int'($urandom_range(0, DT_MAX));
      return int'($urandom_range(0, 262143) >> $urandom_range(0, 6));
   endfunction

   // Mostly ticks, with commands, presets and unused codes mixed in at random.
   task automatic queue_random_requests(input int count);
      int pick;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 12) begin
            queue_request(ACT_SET_CMD, random_angle(), int'($urandom()));
         end else if (pick < 21) begin
            queue_request(ACT_PRESET, random_angle(), int'($urandom()));
         end else if (pick < 25) begin
            queue_request(ACT_NONE, int'($urandom()), int'($urandom()));
         end else begin
            queue_request(ACT_TICK, int'($urandom()), random_dt());
         end
      end
   endtask

   function automatic int random_rate(input bit allow_negative);
      int mag;
      mag = int'($urandom_range(0, RATE_MAX) >> $urandom_range(0, 6));
      if (allow_negative && $urandom_range(0, 3) == 0) return -mag;
      return mag;
   endfunction

   // One register setting per phase, with the extremes in chosen phases.
   task automatic apply_phase_setting(input int phase);
      int lo;
      int hi;
      int rate;
      int frate;
      logic [MODE_W-1:0] mode;
      mode = (phase % 3 == 0) ? MODE_TRACK : ((phase % 3 == 1) ? MODE_RATE : MODE_FIXED);
      if (phase == 6) mode = MODE_HOLD;
      rate = random_rate(1'b1);
      frate = random_rate(1'b0);
      if (phase == 3) rate = RATE_MIN;
      if (phase == 5) begin
         rate = RATE_MAX;
         frate = FRATE_MAX;
      end
      lo = -int'($urandom_range(0, LIMIT_SPAN));
      hi = int'($urandom_range(0, LIMIT_SPAN));
      if (phase == 0) begin
         lo = -LIMIT_SPAN;
         hi = LIMIT_SPAN;
      end else if (phase == 4) begin
         // Crossed limits.
         lo = int'($urandom_range(0, LIMIT_SPAN));
         hi = -int'($urandom_range(0, LIMIT_SPAN));
      end else if (phase == 7) begin
         lo = ANG_LO;
         hi = ANG_HI;
      end
      write_reg(CSR_CONTROL_MODE, mode);
      write_reg(CSR_AXIS_ENABLED, (phase == 7) ? 0 : 1);
      write_reg(CSR_FREE_ROTATE, (phase / 3) % 2);
      write_reg(CSR_TRACKING_RATE, rate);
      write_reg(CSR_FIXED_RATE, frate);
      write_reg(CSR_MIN_LIMIT, lo);
      write_reg(CSR_MAX_LIMIT, hi);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset setting: zero rate, so a tick only pulls the angle into limits.
      queue_request(ACT_SET_CMD, ANG_HI, 0);
      queue_request(ACT_PRESET, ANG_LO, DT_MAX);
      queue_request(ACT_TICK, 0, DT_MAX);
      queue_request(ACT_NONE, int'($urandom()), int'($urandom()));
      queue_request(ACT_PRESET, 0, 0);
      queue_request(ACT_SET_CMD, 0, 0);
      settle();

      // Tracking at full rate: zero time, overshoot with snap, then on target.
      write_reg(CSR_TRACKING_RATE, RATE_MAX);
      queue_request(ACT_SET_CMD, 40960, 0);
      queue_request(ACT_TICK, 0, 0);
      queue_request(ACT_TICK, 0, 1 << 20);
      queue_request(ACT_TICK, 0, 12345);
      settle();

      // A negative rate drives away from the command, up to the limit.
      write_reg(CSR_TRACKING_RATE, RATE_MIN);
      queue_request(ACT_SET_CMD, 0, 0);
      queue_request(ACT_TICK, 0, 1024);
      queue_request(ACT_TICK, 0, DT_MAX);
      settle();

      // Fixed rate at its maximum against crossed limits.
      write_reg(CSR_CONTROL_MODE, MODE_FIXED);
      write_reg(CSR_FIXED_RATE, FRATE_MAX);
      write_reg(CSR_MIN_LIMIT, 100000);
      write_reg(CSR_MAX_LIMIT, -100000);
      queue_request(ACT_TICK, 0, 4096);
      settle();

      // Free rotation wrapping down past a full turn.
      write_reg(CSR_CONTROL_MODE, MODE_RATE);
      write_reg(CSR_FREE_ROTATE, 1);
      write_reg(CSR_TRACKING_RATE, 4096000);
      queue_request(ACT_PRESET, 1474000, 0);
      queue_request(ACT_TICK, 0, 1 << 14);
      settle();

      // Wrapping up past zero, and saturation after a single wrap.
      write_reg(CSR_TRACKING_RATE, -4096000);
      queue_request(ACT_PRESET, 100, 0);
      queue_request(ACT_TICK, 0, 1 << 14);
      queue_request(ACT_PRESET, ANG_HI, 0);
      queue_request(ACT_TICK, 0, DT_MAX);
      settle();

      // Rate only with clamping to the reset limits.
      write_reg(CSR_FREE_ROTATE, 0);
      write_reg(CSR_MIN_LIMIT, MIN_LIMIT_RST);
      write_reg(CSR_MAX_LIMIT, MAX_LIMIT_RST);
      queue_request(ACT_TICK, 0, DT_MAX);
      settle();

      // The unused mode and a disabled axis both hold the angle.
      write_reg(CSR_CONTROL_MODE, MODE_HOLD);
      queue_request(ACT_TICK, 0, 1 << 20);
      settle();
      write_reg(CSR_CONTROL_MODE, MODE_TRACK);
      write_reg(CSR_AXIS_ENABLED, 0);
      queue_request(ACT_TICK, 0, DT_MAX);
      settle();

      // Random phases, one register setting each; the last one runs calm.
      for (int phase = 0; phase < 9; phase++) begin
         apply_phase_setting(phase);
         if (phase == 8) calm = 1'b1;
         queue_random_requests(80);
         if (phase == 3) begin
            @(posedge clock);
            hold_asks++;
         end
         settle();
      end

      repeat (20) @(negedge clock);
      if (fail_count == 0) begin
         $display("PASS gimbal_axis_slew_tracker_unit");
      end else begin
         $display("FAIL gimbal_axis_slew_tracker_unit");
      end
      $finish;
   end

endmodule
